// ===== rtl/msf_pkg.sv =====
// ----------------------------------------------------------------------------
// msf_pkg
// Shared types and constants for the MIDI SysEx filter: register indexes,
// configuration bundle, and controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package msf_pkg;

   localparam int BUFFER_DEPTH_DEF = 32;
   localparam int PREFIX_MAX_DEF   = 8;

   localparam logic [7:0] SYSEX_START = 8'hf0;
   localparam logic [7:0] SYSEX_END   = 8'hf7;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_PAT_A_PREFIX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_A_PREFIX_LEN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_A_TOTAL_LEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_B_PREFIX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_B_PREFIX_LEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAT_B_TOTAL_LEN  = 3'd5;

   localparam logic [5:0] TOTAL_LEN_RESET = 6'd2;

   typedef struct packed {
      logic [63:0] a_prefix;
      logic [3:0]  a_prefix_len;
      logic [5:0]  a_total_len;
      logic [63:0] b_prefix;
      logic [3:0]  b_prefix_len;
      logic [5:0]  b_total_len;
   } cfg_type;

   typedef struct packed {
      logic start;      // store sysex start byte at entry zero
      logic store_wr;   // store byte at current count
      logic count_clr;
      logic out_byte;   // load output register with the input byte
      logic out_mem;    // load output register with buffer read data
      logic rd_clr;
      logic rd_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic is_start;
      logic is_end;
      logic full_next;
      logic match;
      logic rd_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/msf_csr.sv =====
// ----------------------------------------------------------------------------
// msf_csr
// Configuration register file: decodes writes by index and holds both
// drop patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module msf_csr (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [msf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [msf_pkg::CSR_DATA_W-1:0]  csr_data,
   output msf_pkg::cfg_type                cfg
);
   import msf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_PAT_A_PREFIX:     cfg_in.a_prefix     = csr_data;
            REG_PAT_A_PREFIX_LEN: cfg_in.a_prefix_len = csr_data[3:0];
            REG_PAT_A_TOTAL_LEN:  cfg_in.a_total_len  = csr_data[5:0];
            REG_PAT_B_PREFIX:     cfg_in.b_prefix     = csr_data;
            REG_PAT_B_PREFIX_LEN: cfg_in.b_prefix_len = csr_data[3:0];
            REG_PAT_B_TOTAL_LEN:  cfg_in.b_total_len  = csr_data[5:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.a_prefix     <= '0;
         cfg_ff.a_prefix_len <= '0;
         cfg_ff.a_total_len  <= TOTAL_LEN_RESET;
         cfg_ff.b_prefix     <= '0;
         cfg_ff.b_prefix_len <= '0;
         cfg_ff.b_total_len  <= TOTAL_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/msf_dp.sv =====
// ----------------------------------------------------------------------------
// msf_dp
// Datapath: message buffer memory, byte count, prefix capture, pattern
// match, flush read pointer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msf_dp #(
   parameter int BUFFER_DEPTH = msf_pkg::BUFFER_DEPTH_DEF,
   parameter int PREFIX_MAX   = msf_pkg::PREFIX_MAX_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  msf_pkg::cfg_type         cfg,
   input  msf_pkg::dp_cmd_type      cmd,
   output msf_pkg::dp_status_type   status,
   input  wire  [7:0]               req_rx_byte,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_out_last
);
   import msf_pkg::*;

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = (CW > 6) ? CW : 6;

   logic [7:0]    mem [BUFFER_DEPTH];
   logic [7:0]    mem_q_ff;
   logic [AW-1:0] wr_addr;
   logic          wr_en;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cnt_next;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;

   logic [7:0]    pref_ff [PREFIX_MAX];
   logic [8*PREFIX_MAX-1:0] pcur;

   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff, out_byte_in;
   logic          out_last_ff, out_last_in;
   logic          rd_last;

   function automatic logic pattern_hit(input logic [63:0] pat,
                                        input logic [3:0] plen,
                                        input logic [5:0] tlen,
                                        input logic [CW-1:0] cnt,
                                        input logic [8*PREFIX_MAX-1:0] bytes);
      logic [3:0] psat;
      logic       ok;
      psat = (plen > 4'(PREFIX_MAX)) ? 4'(PREFIX_MAX) : plen;
      ok   = (plen != 4'd0) && (LW'(psat) <= LW'(cnt)) && (LW'(cnt) == LW'(tlen));
      for (int i = 0; i < PREFIX_MAX; i++) begin
         if ((4'(i) < psat) && (bytes[8*i +: 8] != pat[8*i +: 8])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   assign cnt_next = count_ff + CW'(1);
   assign wr_en    = cmd.start || cmd.store_wr;
   assign wr_addr  = cmd.start ? '0 : count_ff[AW-1:0];
   assign rd_last  = (CW'(rd_ptr_ff) + CW'(1)) == count_ff;

   // prefix bytes as seen after the current byte is stored
   always_comb begin
      for (int i = 0; i < PREFIX_MAX; i++) begin
         pcur[8*i +: 8] = (CW'(i) == count_ff) ? req_rx_byte : pref_ff[i];
      end
   end

   always_comb begin
      status.is_start  = req_rx_byte == SYSEX_START;
      status.is_end    = req_rx_byte == SYSEX_END;
      status.full_next = cnt_next >= CW'(BUFFER_DEPTH);
      status.match     = pattern_hit(cfg.a_prefix, cfg.a_prefix_len, cfg.a_total_len,
                                     cnt_next, pcur)
                      || pattern_hit(cfg.b_prefix, cfg.b_prefix_len, cfg.b_total_len,
                                     cnt_next, pcur);
      status.rd_last   = rd_last;
      status.out_free  = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.start) begin
         count_in = CW'(1);
      end else if (cmd.store_wr) begin
         count_in = cnt_next;
      end else if (cmd.count_clr) begin
         count_in = '0;
      end
   end

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (cmd.rd_clr) begin
         rd_ptr_in = '0;
      end else if (cmd.rd_inc) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (cmd.out_byte) begin
         out_valid_in = 1'b1;
         out_byte_in  = req_rx_byte;
         out_last_in  = 1'b1;
      end else if (cmd.out_mem) begin
         out_valid_in = 1'b1;
         out_byte_in  = mem_q_ff;
         out_last_in  = rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_rx_byte;
      end
      mem_q_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PREFIX_MAX; i++) begin
         if (wr_en && (CW'(i) == (cmd.start ? CW'(0) : count_ff))) begin
            pref_ff[i] <= req_rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ptr_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_out_last = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/msf_ctrl.sv =====
// ----------------------------------------------------------------------------
// msf_ctrl
// Controller: tracks parse mode (idle, buffering, overflow) and sequences
// the buffer flush one byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module msf_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  msf_pkg::dp_status_type   status,
   output msf_pkg::dp_cmd_type      cmd
);
   import msf_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_PARSE    = 5'b00010,
      S_OVER     = 5'b00100,
      S_FLUSH_RD = 5'b01000,
      S_FLUSH_WR = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      ret_over_ff, ret_over_in;
   logic      takes_item;
   logic      accept;

   assign takes_item = (state_ff == S_IDLE) || (state_ff == S_PARSE) || (state_ff == S_OVER);
   assign req_stall  = !takes_item || !status.out_free;
   assign accept     = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      ret_over_in = ret_over_ff;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status.is_start) begin
                  cmd.start = 1'b1;
                  state_in  = S_PARSE;
               end else begin
                  cmd.out_byte = 1'b1;
               end
            end
         end
         S_PARSE: begin
            if (accept) begin
               cmd.store_wr = 1'b1;
               if (status.is_end) begin
                  if (status.match) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.rd_clr  = 1'b1;
                     ret_over_in = 1'b0;
                     state_in    = S_FLUSH_RD;
                  end
               end else if (status.full_next) begin
                  cmd.rd_clr  = 1'b1;
                  ret_over_in = 1'b1;
                  state_in    = S_FLUSH_RD;
               end
            end
         end
         S_OVER: begin
            if (accept) begin
               cmd.out_byte = 1'b1;
               if (status.is_end) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_FLUSH_RD: begin
            state_in = S_FLUSH_WR;
         end
         S_FLUSH_WR: begin
            if (status.out_free) begin
               cmd.out_mem = 1'b1;
               if (status.rd_last) begin
                  cmd.count_clr = 1'b1;
                  state_in      = ret_over_ff ? S_OVER : S_IDLE;
               end else begin
                  cmd.rd_inc = 1'b1;
                  state_in   = S_FLUSH_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // a matched message leaves nothing buffered
      if (state_ff == S_PARSE && accept && status.is_end && status.match) begin
         cmd.store_wr  = 1'b0;
         cmd.count_clr = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_over_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_over_ff <= ret_over_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/midi_sysex_filter.sv =====
// ----------------------------------------------------------------------------
// midi_sysex_filter
// Outside SysEx a taken byte goes straight into the output register. SysEx bytes
// are buffered; a flush emits them one at a time (registered buffer read, then
// output load, waiting on an output stall) and holds the input meanwhile.
// Otherwise one byte per cycle while the output is not stalled. Synchronous
// reset: idle, buffer and output empty, patterns cleared with total length two.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_sysex_filter #(
   parameter int BUFFER_DEPTH = msf_pkg::BUFFER_DEPTH_DEF,
   parameter int PREFIX_MAX   = msf_pkg::PREFIX_MAX_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_out_last,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [msf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [msf_pkg::CSR_DATA_W-1:0]  csr_data
);
   import msf_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   msf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   msf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msf_dp #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .PREFIX_MAX   (PREFIX_MAX)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for midi_sysex_filter. A clocked driver feeds MIDI bytes
// from a queue that the stimulus process fills, and a second driver sends
// pattern register writes. The monitor keeps its own model of the SysEx
// buffer and the two drop patterns, and it queues the bytes the filter should
// emit. Each emitted byte is checked in order. The run covers pass-through
// bytes, dropped and kept messages, buffer overflow, random idle and stall
// phases, and one long output stall that backs up the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import msf_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 400;

   typedef enum logic [1:0] {PASS_IDLE, SYSEX_BUFFERING, SYSEX_SPILL} parse_state_type;

   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } out_item_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_out_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // stimulus side
   logic [7:0]     byte_queue[$];
   reg_write_type  reg_queue[$];
   int             planned = 0;
   int             gap_pct = 0;
   int             stall_pct = 0;
   int             hold_requests = 0;
   int             holds_served = 0;
   int             hold_left = 0;
   cfg_type        plan_cfg;

   // filter model
   parse_state_type parse_state = PASS_IDLE;
   logic [7:0]     msg_store [0:BUFFER_DEPTH_DEF-1];
   int             msg_count = 0;
   cfg_type        filter_cfg;
   out_item_type   out_bytes_due[$];

   int             mismatches = 0;
   int             bytes_in = 0;
   int             bytes_checked = 0;
   int             writes_done = 0;
   int             dropped_msgs = 0;
   int             overflow_count = 0;
   int             quiet_cycles = 0;

   midi_sysex_filter u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   // ---------------- model ----------------

   function automatic bit pattern_hit(input logic [63:0] pfx, input logic [3:0] plen_raw,
                                      input logic [5:0] total);
      int plen;
      plen = (plen_raw > PREFIX_MAX_DEF) ? PREFIX_MAX_DEF : int'(plen_raw);
      if (plen == 0 || plen > msg_count || msg_count != int'(total))
         return 1'b0;
      for (int i = 0; i < plen; i++)
         if (msg_store[i] != pfx[8*i +: 8])
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic flush_message();
      for (int i = 0; i < msg_count; i++)
         out_bytes_due.push_back(out_item_type'{msg_store[i], i == msg_count - 1});
      msg_count = 0;
   endtask

   task automatic filter_byte(input logic [7:0] rx);
      if (parse_state == SYSEX_BUFFERING && msg_count >= BUFFER_DEPTH_DEF) begin
         parse_state = SYSEX_SPILL;
         msg_count = 0;
      end
      if (parse_state == SYSEX_BUFFERING) begin
         msg_store[msg_count] = rx;
         msg_count++;
         if (rx == SYSEX_END) begin
            parse_state = PASS_IDLE;
            if (pattern_hit(filter_cfg.a_prefix, filter_cfg.a_prefix_len,
                            filter_cfg.a_total_len) ||
                pattern_hit(filter_cfg.b_prefix, filter_cfg.b_prefix_len,
                            filter_cfg.b_total_len)) begin
               msg_count = 0;
               dropped_msgs++;
            end else begin
               flush_message();
            end
         end else if (msg_count >= BUFFER_DEPTH_DEF) begin
            parse_state = SYSEX_SPILL;
            overflow_count++;
            flush_message();
         end
      end else if (parse_state == SYSEX_SPILL) begin
         if (rx == SYSEX_END)
            parse_state = PASS_IDLE;
         out_bytes_due.push_back(out_item_type'{rx, 1'b1});
      end else if (rx == SYSEX_START) begin
         parse_state = SYSEX_BUFFERING;
         msg_store[0] = rx;
         msg_count = 1;
      end else begin
         out_bytes_due.push_back(out_item_type'{rx, 1'b1});
      end
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_PAT_A_PREFIX:     filter_cfg.a_prefix = data;
         REG_PAT_A_PREFIX_LEN: filter_cfg.a_prefix_len = data[3:0];
         REG_PAT_A_TOTAL_LEN:  filter_cfg.a_total_len = data[5:0];
         REG_PAT_B_PREFIX:     filter_cfg.b_prefix = data;
         REG_PAT_B_PREFIX_LEN: filter_cfg.b_prefix_len = data[3:0];
         REG_PAT_B_TOTAL_LEN:  filter_cfg.b_total_len = data[5:0];
         default: ;
      endcase
   endtask

   // ---------------- drivers ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (byte_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_valid <= 1'b1;
            req_rx_byte <= byte_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         holds_served <= hold_requests;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      reg_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!csr_valid || csr_ready) begin
         if (reg_queue.size() != 0) begin
            w = reg_queue.pop_front();
            csr_valid <= 1'b1;
            csr_index <= w.idx;
            csr_data <= w.data;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      out_item_type due;
      bit           busy;
      if (reset) begin
         parse_state = PASS_IDLE;
         msg_count = 0;
         filter_cfg = '0;
         filter_cfg.a_total_len = TOTAL_LEN_RESET;
         filter_cfg.b_total_len = TOTAL_LEN_RESET;
         quiet_cycles = 0;
      end else begin
         busy = 1'b0;
         if (csr_valid && csr_ready) begin
            apply_reg(csr_index, csr_data);
            writes_done++;
            busy = 1'b1;
         end
         if (req_valid && !req_stall) begin
            filter_byte(req_rx_byte);
            bytes_in++;
            busy = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            if (out_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                         rsp_out_byte, rsp_out_last));
            end else begin
               due = out_bytes_due.pop_front();
               if (rsp_out_byte !== due.value)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_out_byte, due.value));
               if (rsp_out_last !== due.is_last)
                  report_mismatch($sformatf("out_last %0b, want %0b on byte %02h",
                                            rsp_out_last, due.is_last, due.value));
               bytes_checked++;
            end
         end
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d output items pending",
                     WATCHDOG_LIMIT, out_bytes_due.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------- stimulus ----------------

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      planned++;
   endtask

   function automatic logic [63:0] rand_prefix();
      logic [63:0] p;
      p[7:0] = SYSEX_START;
      for (int i = 1; i < 8; i++)
         p[8*i +: 8] = 8'($urandom_range(127));
      return p;
   endfunction

   // F0, body, F7 with the pattern prefix laid over the start of the body
   task automatic queue_message(input logic [63:0] pfx, input int plen, input int total,
                                input int flip_pos);
      logic [7:0] b;
      int         len;
      int         np;
      len = (total < 2) ? 2 : (total > 40) ? int'($urandom_range(3, 36)) : total;
      np = (plen > PREFIX_MAX_DEF) ? PREFIX_MAX_DEF : plen;
      for (int i = 0; i < len; i++) begin
         if (i == 0)
            b = SYSEX_START;
         else if (i == len - 1)
            b = SYSEX_END;
         else if (i < np)
            b = pfx[8*i +: 8];
         else if ($urandom_range(15) == 0)
            b = SYSEX_START;
         else
            b = 8'($urandom_range(127));
         if (i == flip_pos)
            b = b ^ (8'h01 << $urandom_range(6));
         queue_byte(b);
      end
   endtask

   task automatic queue_near_miss(input logic [63:0] pfx, input int plen, input int total);
      int np;
      int m;
      np = (plen > PREFIX_MAX_DEF) ? PREFIX_MAX_DEF : plen;
      m = (np < total - 1) ? np : total - 1;
      if (m >= 2 && $urandom_range(1))
         queue_message(pfx, plen, total, $urandom_range(1, m - 1));
      else
         queue_message(pfx, plen, $urandom_range(1) ? total + 1 : total - 1, -1);
   endtask

   task automatic queue_random_traffic(input int count);
      int start_count;
      int pick;
      start_count = planned;
      while (planned - start_count < count) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            queue_message(plan_cfg.a_prefix, plan_cfg.a_prefix_len, plan_cfg.a_total_len, -1);
         end else if (pick < 45) begin
            queue_message(plan_cfg.b_prefix, plan_cfg.b_prefix_len, plan_cfg.b_total_len, -1);
         end else if (pick < 60) begin
            if ($urandom_range(1))
               queue_near_miss(plan_cfg.a_prefix, plan_cfg.a_prefix_len, plan_cfg.a_total_len);
            else
               queue_near_miss(plan_cfg.b_prefix, plan_cfg.b_prefix_len, plan_cfg.b_total_len);
         end else if (pick < 72) begin
            queue_message('0, 0, ($urandom_range(9) == 0) ? $urandom_range(33, 40)
                                                           : $urandom_range(2, 12), -1);
         end else if (pick < 85) begin
            queue_byte(8'($urandom_range(8'h80, 8'hef)));
            repeat ($urandom_range(1, 2)) queue_byte(8'($urandom_range(127)));
         end else begin
            queue_byte(8'($urandom_range(255)));
         end
      end
      // leave the filter outside any message
      queue_byte(SYSEX_END);
   endtask

   task automatic wait_idle();
      while (byte_queue.size() != 0 || req_valid || out_bytes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_patterns(input cfg_type c);
      reg_queue.push_back(reg_write_type'{REG_PAT_A_PREFIX, c.a_prefix});
      reg_queue.push_back(reg_write_type'{REG_PAT_A_PREFIX_LEN, 64'(c.a_prefix_len)});
      reg_queue.push_back(reg_write_type'{REG_PAT_A_TOTAL_LEN, 64'(c.a_total_len)});
      reg_queue.push_back(reg_write_type'{REG_PAT_B_PREFIX, c.b_prefix});
      reg_queue.push_back(reg_write_type'{REG_PAT_B_PREFIX_LEN, 64'(c.b_prefix_len)});
      reg_queue.push_back(reg_write_type'{REG_PAT_B_TOTAL_LEN, 64'(c.b_total_len)});
      plan_cfg = c;
      do @(negedge clock); while (reg_queue.size() != 0 || csr_valid);
   endtask

   initial begin : stimulus
      cfg_type    c;
      logic [7:0] opening [12] = '{8'h00, 8'h7f, 8'h80, 8'hff, SYSEX_END,
                                   SYSEX_START, SYSEX_END,
                                   SYSEX_START, 8'h55, SYSEX_START, 8'h2a, SYSEX_END};
      logic [7:0] second [5] = '{SYSEX_START, SYSEX_END, SYSEX_START, 8'h01, SYSEX_END};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default patterns disable matching
      foreach (opening[i]) queue_byte(opening[i]);
      wait_idle();

      // pattern a fills the buffer exactly, pattern b drops the bare F0 F7
      c.a_prefix = rand_prefix();
      c.a_prefix_len = 4'd8;
      c.a_total_len = 6'd32;
      c.b_prefix = rand_prefix();
      c.b_prefix_len = 4'd1;
      c.b_total_len = 6'd2;
      set_patterns(c);
      foreach (second[i]) queue_byte(second[i]);
      queue_random_traffic(35);
      wait_idle();

      // saturated prefix length, pattern b disabled
      c.a_prefix = rand_prefix();
      c.a_prefix_len = 4'd15;
      c.a_total_len = 6'd12;
      c.b_prefix = '1;
      c.b_prefix_len = 4'd0;
      c.b_total_len = 6'd63;
      set_patterns(c);
      gap_pct = 51;
      queue_random_traffic(35);
      wait_idle();

      // pattern b prefix longer than its total length
      c.a_prefix = rand_prefix();
      c.a_prefix_len = 4'd3;
      c.a_total_len = 6'($urandom_range(4, 16));
      c.b_prefix = '0;
      c.b_prefix_len = 4'd5;
      c.b_total_len = 6'd4;
      set_patterns(c);
      gap_pct = 0;
      stall_pct = 51;
      queue_random_traffic(35);
      wait_idle();

      c.a_prefix = rand_prefix();
      c.a_prefix_len = 4'd2;
      c.a_total_len = 6'd5;
      c.b_prefix = rand_prefix();
      c.b_prefix_len = 4'd4;
      c.b_total_len = 6'd0;
      set_patterns(c);
      gap_pct = 19;
      stall_pct = 19;
      queue_random_traffic(35);
      wait_idle();

      // long output stall while an overflowing message and plain bytes keep coming
      gap_pct = 0;
      stall_pct = 0;
      hold_requests++;
      queue_message('0, 0, 36, -1);
      repeat (20) queue_byte(8'($urandom_range(127)));
      queue_byte(SYSEX_END);
      wait_idle();

      $display("sent %0d bytes, checked %0d output bytes, %0d register writes",
               bytes_in, bytes_checked, writes_done);
      $display("%0d messages dropped by pattern, %0d buffer overflows",
               dropped_msgs, overflow_count);
      if (out_bytes_due.size() != 0)
         report_mismatch($sformatf("%0d output items never arrived", out_bytes_due.size()));
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
